// ----- hw/rtl/ffla_pkg.sv -----
// Shared widths, codes and controller/datapath interface types for the line allocator.
package ffla_pkg;

   // Default number of line slots
   localparam int SLOT_COUNT_DEF = 1024;

   // Field widths
   localparam int START_W = 10;
   localparam int COUNT_W = 11;
   localparam int PN_W    = 16;

   // Stream widths
   localparam int REQ_TDATA_W  = 24;
   localparam int REQ_TUSER_W  = 1;
   localparam int RSP_FIELDS_W = 1 + START_W + PN_W;
   localparam int RSP_TDATA_W  = 32;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;    // latch the request fields
      logic set_ok;     // mark the current item as successful
      logic scan_init;  // reset scan pointer and run tracking
      logic scan_run;   // read next slot, evaluate previous one
      logic mark_init;  // load write pointer with the found run
      logic free_init;  // load write pointer with the free range
      logic write_run;  // write one slot, advance pointer
      logic rsp_load;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic op_alloc;     // captured item is an allocate
      logic alloc_cnt_ok; // allocate count in range
      logic free_rng_ok;  // free range inside the map
      logic found;        // scan hit a long enough free run
      logic scan_end;     // last slot evaluated
      logic write_last;   // final write of a run or clear pass
      logic rsp_busy;     // result register still occupied
   } sts_type;

endpackage

// ----- hw/rtl/ffla_ctrl.sv -----
// Sequencing state machine for the line allocator.
module ffla_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ffla_pkg::sts_type sts,
   output ffla_pkg::cmd_type cmd
);
   import ffla_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.write_run = 1'b1;
            if (sts.write_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.op_alloc) begin
               if (sts.alloc_cnt_ok) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (sts.free_rng_ok) begin
               cmd.free_init = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = ST_WRITE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.found) begin
               cmd.mark_init = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = ST_WRITE;
            end else if (sts.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.write_run = 1'b1;
            if (sts.write_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ----- hw/rtl/ffla_dp.sv -----
// Datapath: slot map memory, scan and write pointers, process counter, result register.
module ffla_dp #(
   parameter int SLOT_COUNT = ffla_pkg::SLOT_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ffla_pkg::cmd_type                  cmd,
   output ffla_pkg::sts_type                  sts,
   input  logic [ffla_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [ffla_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ffla_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ffla_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   // compare width: holds start + count and the slot total
   localparam int CW    = (CNT_W > START_W + 2) ? CNT_W : START_W + 2;
   localparam int EW    = (IDX_W > START_W) ? IDX_W : START_W;

   // Captured request
   logic               op_ff;
   logic [START_W-1:0] start_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               ok_ff;

   // Scan state
   logic [IDX_W-1:0]   rd_ptr_ff;
   logic               chk_vld_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               rdata_ff;
   logic [CNT_W-1:0]   run_len_ff;
   logic [IDX_W-1:0]   run_begin_ff;

   // Write state
   logic [IDX_W-1:0]   wr_ptr_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic               wr_val_ff;

   // Process counter and result
   logic [PN_W-1:0]        next_pn_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic slot_used_mem [SLOT_COUNT];

   // Derived values
   logic [CW-1:0]          cnt_ext;
   logic [CW-1:0]          start_ext;
   logic [CW-1:0]          limit;
   logic [CNT_W-1:0]       cnt_trunc;
   logic [CNT_W-1:0]       run_len_inc;
   logic                   slot_free;
   logic                   found;
   logic [IDX_W-1:0]       found_start;
   logic                   alloc_ok;
   logic [EW-1:0]          run_begin_ext;
   logic [START_W-1:0]     start_field;
   logic [PN_W-1:0]        pn_field;
   logic [RSP_TDATA_W-1:0] rsp_next;

   always_comb begin
      cnt_ext       = CW'(cnt_ff);
      start_ext     = CW'(start_ff);
      limit         = CW'(SLOT_COUNT);
      cnt_trunc     = cnt_ext[CNT_W-1:0];
      run_len_inc   = run_len_ff + 1'b1;
      slot_free     = !rdata_ff;
      found         = chk_vld_ff && slot_free && (CW'(run_len_inc) == cnt_ext);
      found_start   = (run_len_ff == '0) ? chk_idx_ff : run_begin_ff;
      alloc_ok      = (op_ff == OP_ALLOC) && ok_ff;
      run_begin_ext = EW'(run_begin_ff);
      start_field   = alloc_ok ? run_begin_ext[START_W-1:0] : '0;
      pn_field      = alloc_ok ? next_pn_ff : '0;
      rsp_next      = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, pn_field, start_field, ok_ff};
   end

   // Status to the controller
   always_comb begin
      sts.op_alloc     = (op_ff == OP_ALLOC);
      sts.alloc_cnt_ok = (cnt_ext != '0) && (cnt_ext <= limit);
      sts.free_rng_ok  = (cnt_ext != '0) && ((start_ext + cnt_ext) <= limit);
      sts.found        = found;
      sts.scan_end     = chk_vld_ff && (chk_idx_ff == IDX_W'(SLOT_COUNT - 1));
      sts.write_last   = (rem_ff == CNT_W'(1));
      sts.rsp_busy     = rsp_tvalid_ff && !rsp_tready;
   end

   // Request capture and success flag
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser[0];
         start_ff <= req_tdata[START_W-1:0];
         cnt_ff   <= req_tdata[START_W +: COUNT_W];
         ok_ff    <= 1'b0;
      end else if (cmd.set_ok) begin
         ok_ff <= 1'b1;
      end
   end

   // Slot map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_run) begin
         slot_used_mem[wr_ptr_ff] <= wr_val_ff;
      end
      rdata_ff <= slot_used_mem[rd_ptr_ff];
   end

   // Scan pointer; the slot read is registered, so each slot is evaluated in the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= cmd.scan_run;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         rd_ptr_ff  <= '0;
         run_len_ff <= '0;
      end else if (cmd.scan_run) begin
         chk_idx_ff <= rd_ptr_ff;
         if (rd_ptr_ff != IDX_W'(SLOT_COUNT - 1)) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (chk_vld_ff) begin
            if (slot_free) begin
               if (run_len_ff == '0) begin
                  run_begin_ff <= chk_idx_ff;
               end
               run_len_ff <= run_len_inc;
            end else begin
               run_len_ff <= '0;
            end
         end
      end
   end

   // Write pointer: clear pass after reset, run marking, range freeing
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rem_ff    <= CNT_W'(SLOT_COUNT);
         wr_val_ff <= 1'b0;
      end else if (cmd.mark_init) begin
         wr_ptr_ff <= found_start;
         rem_ff    <= cnt_trunc;
         wr_val_ff <= 1'b1;
      end else if (cmd.free_init) begin
         wr_ptr_ff <= start_ext[IDX_W-1:0];
         rem_ff    <= cnt_trunc;
         wr_val_ff <= 1'b0;
      end else if (cmd.write_run) begin
         wr_ptr_ff <= wr_ptr_ff + 1'b1;
         rem_ff    <= rem_ff - 1'b1;
      end
   end

   // Process number counter
   always_ff @(posedge clock) begin
      if (reset) begin
         next_pn_ff <= '0;
      end else if (cmd.rsp_load && alloc_ok) begin
         next_pn_ff <= next_pn_ff + 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_run |-> !cmd.write_run)
      else $error("slot map written during a scan");

   a_run_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_init |-> ((CW'(found_start) + cnt_ext) <= limit))
      else $error("found run extends past the slot map");

   a_pn_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && alloc_ok) |=> (next_pn_ff == $past(next_pn_ff) + 1'b1))
      else $error("process number did not advance on allocation");
`endif

endmodule

// ----- hw/rtl/first_fit_line_allocator.sv -----
// An allocate scans the slot map for the first long enough free run, then marks it;
// a free clears its range; a rejected count or range goes straight to the result;
// an allocate with no free run scans the whole map before its result.
// Throughput: one item at a time, bounded by the slot map scan and fill.
// The result register lets the next item start while a result waits for rsp_tready.
// Reset: synchronous; a clearing pass zeroes every slot of the map first.
module first_fit_line_allocator #(
   parameter int SLOT_COUNT = ffla_pkg::SLOT_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] start_slot, [20:10] slot_count, [23:21] zero
   input  logic [ffla_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] operation
   input  logic [ffla_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] ok, [10:1] run_start, [26:11] process_number, [31:27] zero
   output logic [ffla_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import ffla_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   ffla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Slot map and result path
   ffla_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- tb/first_fit_line_allocator_test.sv -----
// Self-checking stream testbench for the first-fit line slot allocator.
module first_fit_line_allocator_test;
   import ffla_pkg::*;

   localparam int SLOTS         = SLOT_COUNT_DEF;
   localparam int RANDOM_ITEMS  = 560;
   localparam int HOLD_CYCLES   = 4000;
   localparam int DRAIN_CYCLES  = 2 * SLOTS + 16;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int PLAN_ROWS     = 23;

   // One reply of the allocator
   typedef struct packed {
      logic            ok;
      logic [START_W-1:0] run_start;
      logic [PN_W-1:0] process_number;
   } grant_type;

   // One directed request, with the reply typed in where it is obvious
   typedef struct packed {
      logic            op;
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] count;
      logic            typed;
      grant_type       grant;
   } row_type;

   // Run handed out by the allocator and not yet returned
   typedef struct {
      int first;
      int span;
   } run_type;

   localparam row_type PLAN [PLAN_ROWS] = '{
      '{OP_ALLOC, 10'd0,    11'd0,    1'b1, '{1'b0, 10'd0, 16'd0}},  // zero count
      '{OP_ALLOC, 10'd0,    11'd1025, 1'b1, '{1'b0, 10'd0, 16'd0}},  // oversized count
      '{OP_ALLOC, 10'd0,    11'd2047, 1'b1, '{1'b0, 10'd0, 16'd0}},  // largest field value
      '{OP_ALLOC, 10'd0,    11'd1,    1'b1, '{1'b1, 10'd0, 16'd0}},
      '{OP_ALLOC, 10'd0,    11'd3,    1'b1, '{1'b1, 10'd1, 16'd1}},
      '{OP_FREE,  10'd0,    11'd1,    1'b1, '{1'b1, 10'd0, 16'd0}},
      '{OP_ALLOC, 10'd0,    11'd2,    1'b0, '0},                       // skips the hole at 0
      '{OP_ALLOC, 10'd0,    11'd1,    1'b0, '0},                       // fills the hole
      '{OP_FREE,  10'd1,    11'd0,    1'b1, '{1'b0, 10'd0, 16'd0}},  // zero-length free
      '{OP_FREE,  10'd1023, 11'd2,    1'b1, '{1'b0, 10'd0, 16'd0}},  // runs past the top
      '{OP_FREE,  10'd1023, 11'd1,    1'b1, '{1'b1, 10'd0, 16'd0}},  // ends at the top
      '{OP_FREE,  10'd0,    11'd1024, 1'b1, '{1'b1, 10'd0, 16'd0}},  // whole map
      '{OP_ALLOC, 10'd0,    11'd1024, 1'b1, '{1'b1, 10'd0, 16'd4}},  // whole map
      '{OP_ALLOC, 10'd0,    11'd1,    1'b1, '{1'b0, 10'd0, 16'd0}},  // map full
      '{OP_FREE,  10'd512,  11'd1024, 1'b1, '{1'b0, 10'd0, 16'd0}},
      '{OP_FREE,  10'd1000, 11'd24,   1'b1, '{1'b1, 10'd0, 16'd0}},
      '{OP_ALLOC, 10'd0,    11'd25,   1'b0, '0},                       // one slot short
      '{OP_ALLOC, 10'd0,    11'd24,   1'b0, '0},                       // exact fit at the top
      '{OP_FREE,  10'd0,    11'd2047, 1'b1, '{1'b0, 10'd0, 16'd0}},
      '{OP_ALLOC, 10'd1023, 11'd1,    1'b0, '0},                       // start ignored
      '{OP_FREE,  10'd1,    11'd1023, 1'b1, '{1'b1, 10'd0, 16'd0}},
      '{OP_ALLOC, 10'd0,    11'd1023, 1'b0, '0},
      '{OP_FREE,  10'd0,    11'd1024, 1'b1, '{1'b1, 10'd0, 16'd0}}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   // Predictor state: used bit per slot and the next process number
   logic [SLOTS-1:0]        slot_map = '0;
   logic [PN_W-1:0]         pn_next = '0;

   grant_type               grant_queue [$];
   run_type                 live_runs [$];
   grant_type               want;
   grant_type               got;
   int                      error_count = 0;
   int                      cycle_count = 0;
   bit                      steady_flow = 1'b0;
   bit                      hold_go = 1'b0;
   bit                      hold_done = 1'b0;

   first_fit_line_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // First-fit scan, mark and clear on the predictor's own slot map
   function automatic grant_type compute_grant(input logic op,
                                               input logic [START_W-1:0] start,
                                               input logic [COUNT_W-1:0] count);
      grant_type g;
      int     run_len;
      int     run_begin;
      int     hit;
      int     i;
      g = '0;
      run_len = 0;
      run_begin = 0;
      hit = -1;
      if (op == OP_ALLOC) begin
         if (count >= 1 && int'(count) <= SLOTS) begin
            for (i = 0; i < SLOTS && hit < 0; i++) begin
               if (!slot_map[i]) begin
                  if (run_len == 0) run_begin = i;
                  run_len++;
                  if (run_len == int'(count)) hit = run_begin;
               end else begin
                  run_len = 0;
               end
            end
         end
         if (hit >= 0) begin
            for (i = hit; i < hit + int'(count); i++) slot_map[i] = 1'b1;
            g.ok = 1'b1;
            g.run_start = hit[START_W-1:0];
            g.process_number = pn_next;
            pn_next = pn_next + 1'b1;
         end
      end else if (count >= 1 && int'(start) + int'(count) <= SLOTS) begin
         for (i = int'(start); i < int'(start) + int'(count); i++) slot_map[i] = 1'b0;
         g.ok = 1'b1;
      end
      return g;
   endfunction

   // Offer one request, wait for its transfer, then queue the expected reply
   task automatic offer_request(input logic op, input logic [START_W-1:0] start,
                                input logic [COUNT_W-1:0] count, input bit typed,
                                input grant_type typed_grant);
      grant_type g;
      run_type   r;
      while (!steady_flow && $urandom_range(0, 99) < 35) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {{(REQ_TDATA_W - START_W - COUNT_W){1'b0}}, count, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      g = compute_grant(op, start, count);
      if (op == OP_ALLOC && g.ok) begin
         r.first = int'(g.run_start);
         r.span = int'(count);
         live_runs.push_back(r);
      end
      grant_queue.push_back(typed ? typed_grant : g);
      @(negedge clock);
   endtask

   // Mostly allocations and frees of live runs; the rest stray frees, bad counts and allocations of any size
   task automatic offer_random_request();
      int                 pick;
      int                 idx;
      logic               op;
      logic [START_W-1:0] s;
      logic [COUNT_W-1:0] c;
      pick = $urandom_range(0, 99);
      if ($countones(slot_map) > 850 && live_runs.size() > 0) pick = 60;
      s = START_W'($urandom);
      op = OP_ALLOC;
      if (pick < 45) begin
         c = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom_range(17, SLOTS))
                                          : COUNT_W'($urandom_range(1, 16));
      end else if (pick < 78 && live_runs.size() > 0) begin
         idx = $urandom_range(0, live_runs.size() - 1);
         op = OP_FREE;
         s = START_W'(live_runs[idx].first);
         c = COUNT_W'(live_runs[idx].span);
         live_runs.delete(idx);
      end else if (pick < 88) begin
         op = OP_FREE;
         c = $urandom_range(0, 1) ? COUNT_W'($urandom_range(1, SLOTS - int'(s)))
                                  : COUNT_W'($urandom_range(0, 2047));
      end else if (pick < 94) begin
         c = $urandom_range(0, 1) ? '0 : COUNT_W'($urandom_range(SLOTS + 1, 2047));
      end else begin
         c = COUNT_W'($urandom_range(1, SLOTS));
      end
      offer_request(op, s, c, 1'b0, '0);
   endtask

   // Stimulus: directed table, then random traffic
   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      for (int k = 0; k < PLAN_ROWS; k++) begin
         offer_request(PLAN[k].op, PLAN[k].start, PLAN[k].count, PLAN[k].typed, PLAN[k].grant);
      end
      live_runs.delete();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 20) hold_go = 1'b1;
         steady_flow = (k >= 250 && k < 350);
         offer_random_request();
      end
      steady_flow = 1'b0;
      req_tvalid = 1'b0;

      while (grant_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("first_fit_line_allocator_test OK");
      end else begin
         $display("first_fit_line_allocator_test NOT OK");
      end
      $finish;
   end

   // Reply side ready: random gaps, plus one long hold that backs up the block
   initial begin
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = steady_flow || ($urandom_range(0, 99) >= 35);
      end
   end

   // Compare each reply transfer with the oldest expected reply
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok = rsp_tdata[0];
         got.run_start = rsp_tdata[START_W:1];
         got.process_number = rsp_tdata[START_W+PN_W:START_W+1];
         if (grant_queue.size() == 0) begin
            $error("reply with none expected: ok %0d run_start %0d process_number %0d",
                   got.ok, got.run_start, got.process_number);
            error_count++;
         end else begin
            want = grant_queue.pop_front();
            if (got.ok !== want.ok) begin
               $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
               error_count++;
            end
            if (got.run_start !== want.run_start) begin
               $error("run_start mismatch: expected %0d, got %0d",
                      want.run_start, got.run_start);
               error_count++;
            end
            if (got.process_number !== want.process_number) begin
               $error("process_number mismatch: expected %0d, got %0d",
                      want.process_number, got.process_number);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("first_fit_line_allocator_test NOT OK");
      $finish;
   end

endmodule
